// ===== hw/rtl/mdev_pkg.sv =====
// Shared types and constants for the motor drive / encoder velocity unit.
package mdev_pkg;

    localparam int SPEED_W = 16;   // speed command, Q1.15
    localparam int DUTY_W  = 16;   // PWM duty, Q0.15, 0..32768
    localparam int COEF_W  = 16;   // speed limit and filter weight, Q0.16
    localparam int CNT_W   = 16;   // encoder edge count
    localparam int VEL_W   = 24;   // velocity, Q16.8
    localparam int CFG_IDX_W = 2;

    localparam logic [COEF_W-1:0] SPEED_LIMIT_RST   = 16'd19661;
    localparam logic [COEF_W-1:0] FILTER_WEIGHT_RST = 16'd6554;

    localparam logic [CFG_IDX_W-1:0] CFG_REVERSED_WIRING = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LIMIT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_WEIGHT   = 2'd2;

    typedef enum logic [1:0] {
        REQ_DRIVE = 2'd0,
        REQ_EDGE  = 2'd1,
        REQ_TICK  = 2'd2
    } t_req;

    // Per-beat update strobes from the top level to the state holders.
    typedef struct packed {
        logic drive;
        logic edge_up;
        logic tick;
    } t_cmd;

endpackage

// ===== hw/rtl/mdev_drive.sv =====
// Drive command path: scaled duty magnitude and direction pin.
module mdev_drive
    import mdev_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cmd                      i_cmd,
    input  logic signed [SPEED_W-1:0] i_speed,
    input  logic                      i_reversed,
    input  logic [COEF_W-1:0]         i_limit,
    output logic                      o_dir,
    output logic                      o_dir_next,
    output logic [DUTY_W-1:0]         o_duty_next
);

    logic              r_dir;
    logic [DUTY_W-1:0] r_duty;
    logic [SPEED_W-1:0] mag;
    logic [31:0]        prod;
    logic [31:0]        rnd;
    logic               neg;
    logic               dir_new;
    logic [DUTY_W-1:0]  duty_new;

    // |speed| fits 16 bits unsigned (max 32768)
    assign mag      = i_speed[SPEED_W-1] ? (~i_speed + 16'd1) : i_speed;
    assign prod     = {16'd0, mag} * {16'd0, i_limit};
    assign rnd      = prod + 32'd32768;          // max is exactly 2^31
    assign duty_new = rnd[31:16];
    assign neg      = i_speed[SPEED_W-1] && (i_limit != '0);
    assign dir_new  = i_reversed ? neg : !neg;

    assign o_dir_next  = i_cmd.drive ? dir_new  : r_dir;
    assign o_duty_next = i_cmd.drive ? duty_new : r_duty;
    assign o_dir       = r_dir;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir  <= 1'b0;
            r_duty <= '0;
        end else if (i_cmd.drive) begin
            r_dir  <= dir_new;
            r_duty <= duty_new;
        end
    end

endmodule

// ===== hw/rtl/mdev_count.sv =====
// Saturating signed encoder edge counter, cleared on velocity tick.
module mdev_count
    import mdev_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    input  logic                    i_dir,
    output logic signed [CNT_W-1:0] o_count,
    output logic signed [CNT_W-1:0] o_count_next
);

    localparam logic signed [CNT_W-1:0] CNT_MAX = {1'b0, {(CNT_W-1){1'b1}}};
    localparam logic signed [CNT_W-1:0] CNT_MIN = {1'b1, {(CNT_W-1){1'b0}}};

    logic signed [CNT_W-1:0] r_count;
    logic signed [CNT_W-1:0] n_count;

    always_comb begin
        n_count = r_count;
        if (i_cmd.tick) begin
            n_count = '0;
        end else if (i_cmd.edge_up) begin
            if (i_dir) begin
                if (r_count != CNT_MAX) n_count = r_count + 16'sd1;
            end else begin
                if (r_count != CNT_MIN) n_count = r_count - 16'sd1;
            end
        end
    end

    assign o_count      = r_count;
    assign o_count_next = n_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

endmodule

// ===== hw/rtl/mdev_vel.sv =====
// Exponential moving average of the edge count, Q16.8, rounded and saturated.
module mdev_vel
    import mdev_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    input  logic signed [CNT_W-1:0] i_count,
    input  logic [COEF_W-1:0]       i_weight,
    output logic signed [VEL_W-1:0] o_vel_next
);

    // w*c*256 + (1-w)*v == w*(c*256 - v) + v*2^16: one multiply
    localparam int DIFF_W = VEL_W + 1;
    localparam int PROD_W = DIFF_W + COEF_W + 1;
    localparam int SUM_W  = PROD_W + 1;
    localparam int Q_W    = SUM_W - 16;

    localparam logic signed [Q_W-1:0] VMAX = Q_W'(8388607);
    localparam logic signed [Q_W-1:0] VMIN = -Q_W'(8388608);

    logic signed [VEL_W-1:0]  r_vel;
    logic signed [DIFF_W-1:0] diff;
    logic signed [COEF_W:0]   w_s;
    logic signed [PROD_W-1:0] prod;
    logic signed [SUM_W-1:0]  sum;
    logic signed [Q_W-1:0]    q;
    logic signed [VEL_W-1:0]  vel_new;

    assign diff = DIFF_W'(signed'({i_count, 8'd0})) - DIFF_W'(r_vel);
    assign w_s  = signed'({1'b0, i_weight});
    assign prod = PROD_W'(diff) * PROD_W'(w_s);
    assign sum  = SUM_W'(prod) + (SUM_W'(r_vel) <<< 16) + SUM_W'(32768);
    assign q    = sum[SUM_W-1:16];   // floor divide by 2^16

    always_comb begin
        priority if (q > VMAX) vel_new = VMAX[VEL_W-1:0];
        else if (q < VMIN)     vel_new = VMIN[VEL_W-1:0];
        else                   vel_new = q[VEL_W-1:0];
    end

    assign o_vel_next = i_cmd.tick ? vel_new : r_vel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vel <= '0;
        end else if (i_cmd.tick) begin
            r_vel <= vel_new;
        end
    end

endmodule

// ===== hw/rtl/motor_drive_encoder_velocity_unit.sv =====
// Top level: one-wheel PWM/direction drive with encoder EMA velocity.
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid/s_axis_tready    tuser=req_type, tdata=speed_command
//  m_axis    out  m_axis_tvalid/m_axis_tready    tdata=dir,duty,velocity,count
//  cfg       in   i_cfg_valid/o_cfg_ready        i_cfg_index, i_cfg_data
//
// One beat per cycle sustained while m_axis_tready holds; a beat's result
// passes through the input register, then the result register, to m_axis.
// The limit on rate is the state loop: each beat's update (one 16x16
// multiply for a drive, one 17x25 multiply for a tick) is combinational
// between the input register and the state/result registers.
// Reset (i_rst_n low, synchronous) empties both stages, restores register
// defaults and clears direction, duty, count and velocity.
// Backpressure on m_axis holds the result register; the input register keeps
// taking beats until it is also full.
module motor_drive_encoder_velocity_unit
    import mdev_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [15:0]          s_axis_tdata,   // [15:0] speed_command
    input  logic [1:0]           s_axis_tuser,   // [1:0] req_type

    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [0] direction, [16:1] pwm_duty, [40:17] velocity, [56:41] edge_count,
    // [63:57] zero
    output logic [63:0]          m_axis_tdata,

    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]          i_cfg_data
);

    // config registers
    logic              r_reversed;
    logic [COEF_W-1:0] r_limit;
    logic [COEF_W-1:0] r_weight;

    // input stage
    logic                      r_in_valid;
    t_req                      r_in_req;
    logic signed [SPEED_W-1:0] r_in_speed;

    // result stage
    logic        r_out_valid;
    logic [63:0] r_out_data;

    logic  fire;
    t_cmd  cmd;

    logic                    dir_cur;
    logic                    dir_next;
    logic [DUTY_W-1:0]       duty_next;
    logic signed [CNT_W-1:0] count_cur;
    logic signed [CNT_W-1:0] count_next;
    logic signed [VEL_W-1:0] vel_next;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reversed <= 1'b0;
            r_limit    <= SPEED_LIMIT_RST;
            r_weight   <= FILTER_WEIGHT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_REVERSED_WIRING: r_reversed <= i_cfg_data[0];
                CFG_SPEED_LIMIT:     r_limit    <= i_cfg_data;
                CFG_FILTER_WEIGHT:   r_weight   <= i_cfg_data;
                default: ;           // unmapped index: ignored
            endcase
        end
    end

    // process the held beat when the result register is free or draining
    assign fire          = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || fire;

    always_comb begin
        cmd = '0;
        if (fire) begin
            unique case (r_in_req)
                REQ_DRIVE: cmd.drive   = 1'b1;
                REQ_EDGE:  cmd.edge_up = 1'b1;
                REQ_TICK:  cmd.tick    = 1'b1;
                default: ;   // unused code: state unchanged, result repeats it
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_req   <= t_req'(s_axis_tuser);
            r_in_speed <= signed'(s_axis_tdata);
        end
    end

    mdev_drive u_drive (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_speed     (r_in_speed),
        .i_reversed  (r_reversed),
        .i_limit     (r_limit),
        .o_dir       (dir_cur),
        .o_dir_next  (dir_next),
        .o_duty_next (duty_next)
    );

    // edge direction comes from the pin as left by earlier beats
    mdev_count u_count (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_dir        (dir_cur),
        .o_count      (count_cur),
        .o_count_next (count_next)
    );

    // tick uses the count before it is cleared
    mdev_vel u_vel (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_count    (count_cur),
        .i_weight   (r_weight),
        .o_vel_next (vel_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_data <= {7'd0, count_next, vel_next, duty_next, dir_next};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule
